### hw/rtl/frup_pkg.sv
// Shared types, widths and helpers for the unpolarized Fresnel reflectance unit.
// Used by the square-root cell, the divider cell and the top level.
package frup_pkg;

	localparam int FRAC    = 24;
	localparam int FX_W    = FRAC + 1;
	localparam int IDX_W   = 16;
	localparam int CODE_W  = 3;
	localparam int SQ_W    = 2 * FRAC + 1;
	localparam int PROD_W  = 2 * FX_W;
	localparam int RND_W   = PROD_W + 1;
	localparam int TERM_W  = RND_W - FRAC + 1;
	localparam int DSQ_W   = 2 * (IDX_W + 1);
	localparam int DEN_W   = DSQ_W + 1;
	localparam int NUM_W   = DEN_W + FX_W;
	localparam int IN_W    = ((2 * IDX_W + FX_W + 7) / 8) * 8;
	localparam int OUT_W   = ((2 * FX_W + CODE_W + 7) / 8) * 8;

	localparam logic [FX_W-1:0]  ONE_FX   = {1'b1, {FRAC{1'b0}}};
	localparam logic [SQ_W-1:0]  SQ_ONE   = {1'b1, {(2 * FRAC){1'b0}}};
	localparam logic [RND_W:0]   HALF_RND = (RND_W + 1)'(1) << (FRAC - 1);

	localparam logic REG_NORMAL_TOL  = 1'b0;
	localparam logic REG_GRAZING_THR = 1'b1;

	typedef enum logic [CODE_W-1:0] {
		CASE_MATCHED = 3'd0,
		CASE_NORMAL  = 3'd1,
		CASE_GRAZING = 3'd2,
		CASE_TIR     = 3'd3,
		CASE_GENERAL = 3'd4
	} case_code_t;

	typedef struct packed {
		logic [SQ_W-1:0] v;
		logic [SQ_W-1:0] res;
		logic [SQ_W-1:0] wgt;
	} sqrt_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [NUM_W-1:0] den_sh;
		logic [FX_W-1:0]  quo;
		logic             ovf;
	} div_t;

	typedef struct packed {
		logic [IDX_W-1:0]  ni;
		logic [IDX_W-1:0]  nt;
		logic [FX_W-1:0]   c;
		logic              matched;
		logic              normal;
		logic              grazing;
		logic              tir;
		logic [DSQ_W-1:0]  dsq;
		logic [DSQ_W-1:0]  ssq;
		logic [FX_W-1:0]   si;
		logic [FX_W-1:0]   st;
		logic [FX_W-1:0]   ct;
		logic [TERM_W-1:0] ta;
		logic [TERM_W-1:0] tb;
		logic [TERM_W-1:0] tc;
		logic [TERM_W-1:0] td;
		logic [FX_W-1:0]   t1;
		logic [FX_W-1:0]   t2;
	} ctx_t;

	function automatic logic [TERM_W-1:0] rnd_fx(input logic [RND_W-1:0] p);
		logic [RND_W:0] t;
		t = {1'b0, p} + HALF_RND;
		return t[RND_W:FRAC];
	endfunction

	function automatic logic [TERM_W-1:0] rnd_absdiff(input logic [RND_W-1:0] p,
			input logic [RND_W-1:0] q);
		logic [TERM_W-1:0] r;
		if (p >= q) begin
			r = rnd_fx(p - q);
		end else begin
			r = rnd_fx(q - p);
		end
		return r;
	endfunction

	function automatic div_t div_init(input logic [NUM_W-1:0] num,
			input logic [DEN_W-1:0] den);
		div_t d;
		d.rem    = num;
		d.den_sh = NUM_W'(den) << FRAC;
		d.quo    = '0;
		d.ovf    = (num >= {den, {FX_W{1'b0}}});
		return d;
	endfunction

	function automatic logic [FX_W-1:0] div_sat(input div_t d);
		logic [FX_W-1:0] r;
		if (d.ovf || (d.quo > ONE_FX)) begin
			r = ONE_FX;
		end else begin
			r = d.quo;
		end
		return r;
	endfunction

endpackage

### hw/rtl/fresnel_reflectance_unpolarized_unit.sv
// Top level of the unpolarized Fresnel reflectance unit: stream ports, registers,
// and five chains of cells. Depends on frup_pkg, frup_sqrt_cell and frup_div_cell.
//
// Takes one item per clock while the pipeline is not held, and returns one result
// per item, in order, through 14 stage registers, the output register and five
// chains of 25 cells (two square roots, three divisions, one result bit per cell).
// The whole pipeline advances together; it holds while a result waits at the
// output and m_tready is low, and s_tready follows that. Write the registers
// only while no item is in flight.
module fresnel_reflectance_unpolarized_unit import frup_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [FX_W-1:0]  cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// index_incident, index_transmit, incidence_cosine, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// reflectance, transmit_cosine, case_code, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	logic en;
	logic [FX_W-1:0] tol_q, graz_q;

	// input stage
	logic [IDX_W-1:0] in_ni, in_nt;
	logic [FX_W-1:0]  in_c, c_sat;
	ctx_t             ctx_in;

	logic [IDX_W:0] d_s1, s_s1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic v_s13, v_s14;
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9;
	ctx_t ctx_s10, ctx_s11, ctx_s12, ctx_s13, ctx_s14;
	sqrt_t sq_s2, sq_s6;
	logic [IDX_W+FX_W-1:0] p_s3;
	div_t dv_s4, dv_s9, dv_s12;
	logic [PROD_W-1:0] pcc_s7, pss_s7, psc_s7, pcs_s7;
	logic [FX_W+TERM_W-1:0] m_s11;
	logic [PROD_W-1:0] q1_s14, q2_s14;

	logic            out_valid_q;
	logic [FX_W-1:0] refl_q, cos_q;
	case_code_t      code_q;

	// combinational helpers
	logic [PROD_W-1:0]       csq, stsq;
	logic [IDX_W+FX_W-1:0]   p_nxt;
	ctx_t                    ctx2_nxt, ctx3_nxt, ctx5_nxt, ctx7_nxt, ctx8_nxt;
	ctx_t                    ctx10_nxt, ctx13_nxt;
	logic [NUM_W-1:0]        num4, num9, num12;
	logic [DEN_W-1:0]        den4, den9, den12;
	logic [PROD_W:0]         fin_sum;
	logic [PROD_W-FRAC-1:0]  fin_r;
	logic [FX_W-1:0]         refl_gen;

	// chains
	logic  sq1_v [FX_W+1];
	sqrt_t sq1_d [FX_W+1];
	ctx_t  sq1_c [FX_W+1];
	logic  sq2_v [FX_W+1];
	sqrt_t sq2_d [FX_W+1];
	ctx_t  sq2_c [FX_W+1];
	logic  dv1_v [FX_W+1];
	div_t  dv1_d [FX_W+1];
	ctx_t  dv1_c [FX_W+1];
	logic  dv2_v [FX_W+1];
	div_t  dv2_d [FX_W+1];
	ctx_t  dv2_c [FX_W+1];
	logic  dv3_v [FX_W+1];
	div_t  dv3_d [FX_W+1];
	ctx_t  dv3_c [FX_W+1];

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({code_q, cos_q, refl_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= '0;
			graz_q <= FX_W'(17);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL_TOL:  tol_q  <= cfg_data;
				REG_GRAZING_THR: graz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		in_ni  = s_tdata[IDX_W-1:0];
		in_nt  = s_tdata[2*IDX_W-1:IDX_W];
		in_c   = s_tdata[2*IDX_W+FX_W-1:2*IDX_W];
		c_sat  = (in_c > ONE_FX) ? ONE_FX : in_c;
		ctx_in = '0;
		ctx_in.ni      = in_ni;
		ctx_in.nt      = in_nt;
		ctx_in.c       = c_sat;
		ctx_in.matched = (in_ni == in_nt);
		ctx_in.normal  = ((ONE_FX - c_sat) <= tol_q);
		ctx_in.grazing = (c_sat < graz_q);
	end

	always_comb begin
		csq   = ctx_s1.c * ctx_s1.c;
		ctx2_nxt     = ctx_s1;
		ctx2_nxt.dsq = d_s1 * d_s1;
		ctx2_nxt.ssq = s_s1 * s_s1;
		p_nxt = sq1_c[FX_W].ni * sq1_d[FX_W].res[FX_W-1:0];
		ctx3_nxt     = sq1_c[FX_W];
		ctx3_nxt.si  = sq1_d[FX_W].res[FX_W-1:0];
		ctx3_nxt.tir = (p_nxt >= (IDX_W + FX_W)'({sq1_c[FX_W].nt, {FRAC{1'b0}}}));
		if (ctx_s3.normal) begin
			num4 = NUM_W'({ctx_s3.dsq, {FRAC{1'b0}}}) + NUM_W'(ctx_s3.ssq >> 1);
			den4 = DEN_W'(ctx_s3.ssq);
		end else begin
			num4 = NUM_W'(p_s3);
			den4 = DEN_W'(ctx_s3.nt);
		end
		ctx5_nxt    = dv1_c[FX_W];
		ctx5_nxt.st = div_sat(dv1_d[FX_W]);
		stsq = ctx_s5.st * ctx_s5.st;
		ctx7_nxt    = sq2_c[FX_W];
		ctx7_nxt.ct = sq2_d[FX_W].res[FX_W-1:0];
		ctx8_nxt    = ctx_s7;
		ctx8_nxt.ta = rnd_absdiff(RND_W'(psc_s7), RND_W'(pcs_s7));
		ctx8_nxt.tb = rnd_fx(RND_W'(pcc_s7) + RND_W'(pss_s7));
		ctx8_nxt.tc = rnd_absdiff(RND_W'(pcc_s7), RND_W'(pss_s7));
		ctx8_nxt.td = rnd_fx(RND_W'(psc_s7) + RND_W'(pcs_s7));
		num9  = (NUM_W'(ctx_s8.ta) << FRAC) + NUM_W'(ctx_s8.td >> 1);
		den9  = DEN_W'(ctx_s8.td);
		ctx10_nxt    = dv2_c[FX_W];
		ctx10_nxt.t1 = div_sat(dv2_d[FX_W]);
		num12 = NUM_W'(m_s11) + NUM_W'(ctx_s11.tb >> 1);
		den12 = DEN_W'(ctx_s11.tb);
		ctx13_nxt    = dv3_c[FX_W];
		ctx13_nxt.t2 = div_sat(dv3_d[FX_W]);
		fin_sum  = {1'b0, q1_s14} + (PROD_W + 1)'(q2_s14) + (PROD_W + 1)'(ONE_FX);
		fin_r    = fin_sum[PROD_W:FRAC+1];
		refl_gen = (fin_r > (PROD_W - FRAC)'(ONE_FX)) ? ONE_FX : fin_r[FX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= sq1_v[FX_W];
			v_s4  <= v_s3;
			v_s5  <= dv1_v[FX_W];
			v_s6  <= v_s5;
			v_s7  <= sq2_v[FX_W];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= dv2_v[FX_W];
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= dv3_v[FX_W];
			v_s14 <= v_s13;
			out_valid_q <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_in;
			d_s1   <= (in_nt > in_ni) ? (IDX_W + 1)'(in_nt - in_ni)
			                          : (IDX_W + 1)'(in_ni - in_nt);
			s_s1   <= (IDX_W + 1)'(in_nt) + (IDX_W + 1)'(in_ni);

			ctx_s2 <= ctx2_nxt;
			sq_s2  <= '{v: SQ_ONE - csq[SQ_W-1:0], res: '0, wgt: SQ_ONE};

			ctx_s3 <= ctx3_nxt;
			p_s3   <= p_nxt;

			ctx_s4 <= ctx_s3;
			dv_s4  <= div_init(num4, den4);

			ctx_s5 <= ctx5_nxt;

			ctx_s6 <= ctx_s5;
			sq_s6  <= '{v: SQ_ONE - stsq[SQ_W-1:0], res: '0, wgt: SQ_ONE};

			ctx_s7 <= ctx7_nxt;
			pcc_s7 <= ctx7_nxt.c * ctx7_nxt.ct;
			pss_s7 <= ctx7_nxt.si * ctx7_nxt.st;
			psc_s7 <= ctx7_nxt.si * ctx7_nxt.ct;
			pcs_s7 <= ctx7_nxt.c * ctx7_nxt.st;

			ctx_s8 <= ctx8_nxt;

			ctx_s9 <= ctx_s8;
			dv_s9  <= div_init(num9, den9);

			ctx_s10 <= ctx10_nxt;

			ctx_s11 <= ctx_s10;
			m_s11   <= ctx_s10.t1 * ctx_s10.tc;

			ctx_s12 <= ctx_s11;
			dv_s12  <= div_init(num12, den12);

			ctx_s13 <= ctx13_nxt;

			ctx_s14 <= ctx_s13;
			q1_s14  <= ctx_s13.t1 * ctx_s13.t1;
			q2_s14  <= ctx_s13.t2 * ctx_s13.t2;

			priority if (ctx_s14.matched) begin
				refl_q <= '0;
				cos_q  <= ctx_s14.c;
				code_q <= CASE_MATCHED;
			end else if (ctx_s14.normal) begin
				refl_q <= ctx_s14.st;
				cos_q  <= ctx_s14.c;
				code_q <= CASE_NORMAL;
			end else if (ctx_s14.grazing) begin
				refl_q <= ONE_FX;
				cos_q  <= '0;
				code_q <= CASE_GRAZING;
			end else if (ctx_s14.tir) begin
				refl_q <= ONE_FX;
				cos_q  <= '0;
				code_q <= CASE_TIR;
			end else begin
				refl_q <= refl_gen;
				cos_q  <= ctx_s14.ct;
				code_q <= CASE_GENERAL;
			end
		end
	end

	assign sq1_v[0] = v_s2;
	assign sq1_d[0] = sq_s2;
	assign sq1_c[0] = ctx_s2;
	assign dv1_v[0] = v_s4;
	assign dv1_d[0] = dv_s4;
	assign dv1_c[0] = ctx_s4;
	assign sq2_v[0] = v_s6;
	assign sq2_d[0] = sq_s6;
	assign sq2_c[0] = ctx_s6;
	assign dv2_v[0] = v_s9;
	assign dv2_d[0] = dv_s9;
	assign dv2_c[0] = ctx_s9;
	assign dv3_v[0] = v_s12;
	assign dv3_d[0] = dv_s12;
	assign dv3_c[0] = ctx_s12;

	for (genvar i = 0; i < FX_W; i++) begin : g_chain
		frup_sqrt_cell u_sq1 (
			.clk, .arst_n, .en,
			.valid_in(sq1_v[i]), .sq_in(sq1_d[i]), .ctx_in(sq1_c[i]),
			.valid_out(sq1_v[i+1]), .sq_out(sq1_d[i+1]), .ctx_out(sq1_c[i+1])
		);
		frup_div_cell u_dv1 (
			.clk, .arst_n, .en,
			.valid_in(dv1_v[i]), .dv_in(dv1_d[i]), .ctx_in(dv1_c[i]),
			.valid_out(dv1_v[i+1]), .dv_out(dv1_d[i+1]), .ctx_out(dv1_c[i+1])
		);
		frup_sqrt_cell u_sq2 (
			.clk, .arst_n, .en,
			.valid_in(sq2_v[i]), .sq_in(sq2_d[i]), .ctx_in(sq2_c[i]),
			.valid_out(sq2_v[i+1]), .sq_out(sq2_d[i+1]), .ctx_out(sq2_c[i+1])
		);
		frup_div_cell u_dv2 (
			.clk, .arst_n, .en,
			.valid_in(dv2_v[i]), .dv_in(dv2_d[i]), .ctx_in(dv2_c[i]),
			.valid_out(dv2_v[i+1]), .dv_out(dv2_d[i+1]), .ctx_out(dv2_c[i+1])
		);
		frup_div_cell u_dv3 (
			.clk, .arst_n, .en,
			.valid_in(dv3_v[i]), .dv_in(dv3_d[i]), .ctx_in(dv3_c[i]),
			.valid_out(dv3_v[i+1]), .dv_out(dv3_d[i+1]), .ctx_out(dv3_c[i+1])
		);
	end

	a_refl_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> refl_q <= ONE_FX)
		else $error("reflectance above one");

	a_full_refl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (code_q == CASE_GRAZING || code_q == CASE_TIR)
		|-> refl_q == ONE_FX && cos_q == '0)
		else $error("full reflection item without unit reflectance and zero cosine");

	a_matched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && code_q == CASE_MATCHED |-> refl_q == '0)
		else $error("matched item with non-zero reflectance");

endmodule

### hw/rtl/frup_sqrt_cell.sv
// One step of the integer square root: a single result bit per cell.
// Depends on frup_pkg for the step state and the item context.
module frup_sqrt_cell import frup_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  sqrt_t sq_in,
	input  ctx_t  ctx_in,
	output logic  valid_out,
	output sqrt_t sq_out,
	output ctx_t  ctx_out
);

	logic [SQ_W:0] trial;
	sqrt_t         nxt;

	always_comb begin
		trial   = {1'b0, sq_in.res} + {1'b0, sq_in.wgt};
		nxt.wgt = sq_in.wgt >> 2;
		if ({1'b0, sq_in.v} >= trial) begin
			nxt.v   = sq_in.v - trial[SQ_W-1:0];
			nxt.res = (sq_in.res >> 1) + sq_in.wgt;
		end else begin
			nxt.v   = sq_in.v;
			nxt.res = sq_in.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_out  <= nxt;
			ctx_out <= ctx_in;
		end
	end

endmodule

### hw/rtl/frup_div_cell.sv
// One restoring division step: a single quotient bit per cell.
// Depends on frup_pkg for the divider state and the item context.
module frup_div_cell import frup_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_in,
	input  div_t dv_in,
	input  ctx_t ctx_in,
	output logic valid_out,
	output div_t dv_out,
	output ctx_t ctx_out
);

	div_t nxt;

	always_comb begin
		nxt.den_sh = dv_in.den_sh >> 1;
		nxt.ovf    = dv_in.ovf;
		if (dv_in.rem >= dv_in.den_sh) begin
			nxt.rem = dv_in.rem - dv_in.den_sh;
			nxt.quo = {dv_in.quo[FX_W-2:0], 1'b1};
		end else begin
			nxt.rem = dv_in.rem;
			nxt.quo = {dv_in.quo[FX_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_out  <= nxt;
			ctx_out <= ctx_in;
		end
	end

endmodule
